@@ rtl/core/mbae_pkg.sv @@
`timescale 1ns / 1ps
// Package for the Mandelbrot area estimator.
// Holds field widths, register indexes and reset values shared by the core and its checker.
package mbae_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 28;

    localparam int GRID_W      = 13;
    localparam int ITER_W      = 16;
    localparam int COUNT_W     = 25;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_POINTS    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITERATIONS = 1'b1;

    localparam logic [GRID_W-1:0]  GRID_RESET = 13'd1024;
    localparam logic [ITER_W-1:0]  ITER_RESET = 16'd1000;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

endpackage

@@ rtl/core/mandelbrot_area_estimator.sv @@
`timescale 1ns / 1ps
// Mandelbrot escape-time area estimator, top level.
// Depends on mbae_pkg for widths, register indexes and reset values.
//
// Usage: each input transaction carries one grid point (row index and column index in
// tdata, tlast marking the final point of a sweep). Each point yields exactly one output
// transaction: the outside flag, the running outside count and, on the transaction that
// carries tlast, the area estimate in unsigned Q3.FRAC_BITS fixed point.
// The configuration port sets the grid size and the iteration limit; write it while idle.
// A point runs two divisions in the shared restoring divider, for its row and its column,
// then the escape loop; a last point adds a third division for the area. The divider
// works on a dividend of D = FRAC_BITS + 29 bits; with the default widths D is 57.
// The escape loop runs on one shared multiplier, three products per iteration. The block
// works on one point at a time: s_axis_tready is high only while the core is idle.
// The result waits in an output register; the core returns to idle once it is loaded, but
// the next result waits while the receiver stalls. Reset clears the count, the sequencer
// and the output valid, and restores the register defaults.
module mandelbrot_area_estimator #(
    parameter int COORD_BITS = mbae_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = mbae_pkg::FRAC_BITS_DEF,
    localparam int IN_W      = ((2 * COORD_BITS + 7) / 8) * 8,
    localparam int AREA_W    = FRAC_BITS + 3,
    localparam int OUT_W     = ((1 + mbae_pkg::COUNT_W + AREA_W + 7) / 8) * 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [mbae_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mbae_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [IN_W-1:0]                      s_axis_tdata,  // row_index, col_index
    input  logic                                 s_axis_tlast,  // last_point
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [OUT_W-1:0]                     m_axis_tdata,  // point_outside, outside_total,
                                                                // area_fixed
    output logic                                 m_axis_tlast   // sweep_done
);

    localparam int FIX_W  = FRAC_BITS + 4;
    localparam int PW     = 2 * FIX_W + 1 - FRAC_BITS;
    localparam int DVSR_W = 2 * mbae_pkg::GRID_W;
    localparam int DW     = FRAC_BITS + DVSR_W + 3;
    localparam int SW     = DW + 2;
    localparam int DCNT_W = $clog2(DW + 1);

    localparam logic [63:0] EPS64 = ((64'd1 << FRAC_BITS) + 64'd5000000) / 64'd10000000;
    localparam logic signed [SW-1:0] EPS_S     = SW'(EPS64);
    localparam logic signed [SW-1:0] TWO_S     = SW'({2'b10, {FRAC_BITS{1'b0}}});
    localparam logic signed [SW-1:0] FOUR_S    = SW'({3'b100, {FRAC_BITS{1'b0}}});
    localparam logic signed [SW-1:0] FIX_MAX_S = SW'({1'b0, {(FIX_W - 1){1'b1}}});
    localparam logic signed [SW-1:0] FIX_MIN_S = ~FIX_MAX_S;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DIV_R     = 4'd1;
    localparam logic [3:0] S_LOAD_I    = 4'd2;
    localparam logic [3:0] S_DIV_I     = 4'd3;
    localparam logic [3:0] S_LOAD_Z    = 4'd4;
    localparam logic [3:0] S_ITER      = 4'd5;
    localparam logic [3:0] S_COUNT     = 4'd6;
    localparam logic [3:0] S_AREA_LOAD = 4'd7;
    localparam logic [3:0] S_DIV_A     = 4'd8;
    localparam logic [3:0] S_FINISH    = 4'd9;

    localparam logic [1:0] PH_RR = 2'd0;
    localparam logic [1:0] PH_II = 2'd1;
    localparam logic [1:0] PH_XY = 2'd2;

    function automatic logic signed [FIX_W-1:0] sat_fix(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        priority if (v > FIX_MAX_S)
        begin
            r = FIX_MAX_S;
        end
        else if (v < FIX_MIN_S)
        begin
            r = FIX_MIN_S;
        end
        else
        begin
            r = v;
        end
        return r[FIX_W-1:0];
    endfunction

    logic [3:0]                       state_reg;
    logic [1:0]                       phase_reg;
    logic [DCNT_W-1:0]                dcnt_reg;
    logic [mbae_pkg::ITER_W-1:0]      it_reg;
    logic [mbae_pkg::COUNT_W-1:0]     count_reg;
    logic [mbae_pkg::GRID_W-1:0]      grid_reg;
    logic [mbae_pkg::ITER_W-1:0]      max_iter_reg;
    logic                             out_valid_reg;

    logic [DW-1:0]                    dvd_reg;
    logic [DVSR_W-1:0]                rem_reg;
    logic [DVSR_W-1:0]                dvsr_reg;
    logic [DVSR_W-1:0]                total_reg;
    logic [COORD_BITS-1:0]            col_reg;
    logic                             last_reg;
    logic                             outside_reg;
    logic signed [FIX_W-1:0]          cr_reg;
    logic signed [FIX_W-1:0]          ci_reg;
    logic signed [FIX_W-1:0]          zr_reg;
    logic signed [FIX_W-1:0]          zi_reg;
    logic signed [PW-1:0]             sq_r_reg;
    logic signed [PW-1:0]             sq_i_reg;
    logic signed [PW-1:0]             xp_reg;
    logic                             flag_out_reg;
    logic [mbae_pkg::COUNT_W-1:0]     total_out_reg;
    logic [AREA_W-1:0]                area_out_reg;
    logic                             last_out_reg;

    logic                             in_accept;
    logic                             out_load;
    logic [mbae_pkg::GRID_W-1:0]      n_eff;
    logic [DVSR_W:0]                  div_shift;
    logic [DVSR_W+1:0]                div_trial;
    logic                             div_ge;
    logic [DVSR_W-1:0]                rem_next;
    logic [DW-1:0]                    dvd_next;
    logic [COORD_BITS+2:0]            row5;
    logic [COORD_BITS+3:0]            col9;
    logic signed [SW-1:0]             coord_wide;
    logic signed [FIX_W-1:0]          coord_fix;
    logic signed [FIX_W:0]            mul_a;
    logic signed [FIX_W-1:0]          mul_b;
    logic signed [2*FIX_W:0]          mul_p;
    logic signed [PW-1:0]             mul_fl;
    logic signed [SW-1:0]             esc_sum;
    logic                             escaped;
    logic signed [FIX_W-1:0]          zr_upd;
    logic signed [FIX_W-1:0]          zi_upd;
    logic [DVSR_W-1:0]                diff;
    logic [DVSR_W+5:0]                diff_x;
    logic [DVSR_W+5:0]                prod45;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == S_FINISH) && (!out_valid_reg || m_axis_tready);
    assign n_eff         = (grid_reg == '0) ? mbae_pkg::GRID_W'(1) : grid_reg;

    assign div_shift = {rem_reg, dvd_reg[DW-1]};
    assign div_trial = {1'b0, div_shift} - {2'b00, dvsr_reg};
    assign div_ge    = !div_trial[DVSR_W+1];
    assign rem_next  = div_ge ? div_trial[DVSR_W-1:0] : div_shift[DVSR_W-1:0];
    assign dvd_next  = {dvd_reg[DW-2:0], div_ge};

    assign row5 = ((COORD_BITS + 3)'(s_axis_tdata[COORD_BITS-1:0]) << 2)
                + (COORD_BITS + 3)'(s_axis_tdata[COORD_BITS-1:0]);
    assign col9 = ((COORD_BITS + 4)'(col_reg) << 3) + (COORD_BITS + 4)'(col_reg);

    assign coord_wide = signed'({2'b00, dvd_reg}) - TWO_S + EPS_S;
    assign coord_fix  = sat_fix((state_reg == S_LOAD_I) ? coord_wide : coord_wide + TWO_S);

    always_comb
    begin
        unique case (phase_reg)
            PH_RR:
            begin
                mul_a = {zr_reg[FIX_W-1], zr_reg};
                mul_b = zr_reg;
            end
            PH_II:
            begin
                mul_a = {zi_reg[FIX_W-1], zi_reg};
                mul_b = zi_reg;
            end
            default:
            begin
                mul_a = {zr_reg, 1'b0};
                mul_b = zi_reg;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign mul_fl  = mul_p[2*FIX_W:FRAC_BITS];
    assign esc_sum = SW'(sq_r_reg) + SW'(sq_i_reg);
    assign escaped = esc_sum > FOUR_S;
    assign zr_upd  = sat_fix(SW'(sq_r_reg) - SW'(sq_i_reg) + SW'(cr_reg));
    assign zi_upd  = sat_fix(SW'(xp_reg) + SW'(ci_reg));

    assign diff   = (DVSR_W'(count_reg) >= total_reg) ? '0 : total_reg - DVSR_W'(count_reg);
    assign diff_x = (DVSR_W + 6)'(diff);
    assign prod45 = (diff_x << 5) + (diff_x << 3) + (diff_x << 2) + diff_x;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_RR;
            dcnt_reg     <= '0;
            it_reg       <= '0;
            count_reg    <= '0;
            grid_reg     <= mbae_pkg::GRID_RESET;
            max_iter_reg <= mbae_pkg::ITER_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    mbae_pkg::REG_GRID_POINTS:
                    begin
                        grid_reg <= cfg_wdata[mbae_pkg::GRID_W-1:0];
                    end
                    default:
                    begin
                        max_iter_reg <= cfg_wdata[mbae_pkg::ITER_W-1:0];
                    end
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        dcnt_reg  <= DCNT_W'(DW);
                        state_reg <= S_DIV_R;
                    end
                end
                S_DIV_R, S_DIV_I, S_DIV_A:
                begin
                    dcnt_reg <= dcnt_reg - DCNT_W'(1);
                    if (dcnt_reg == DCNT_W'(1))
                    begin
                        priority if (state_reg == S_DIV_R)
                        begin
                            state_reg <= S_LOAD_I;
                        end
                        else if (state_reg == S_DIV_I)
                        begin
                            state_reg <= S_LOAD_Z;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_LOAD_I:
                begin
                    dcnt_reg  <= DCNT_W'(DW);
                    state_reg <= S_DIV_I;
                end
                S_LOAD_Z:
                begin
                    it_reg    <= '0;
                    phase_reg <= PH_RR;
                    state_reg <= S_ITER;
                end
                S_ITER:
                begin
                    unique case (phase_reg)
                        PH_RR:
                        begin
                            phase_reg <= PH_II;
                        end
                        PH_II:
                        begin
                            phase_reg <= PH_XY;
                        end
                        default:
                        begin
                            priority if ((it_reg != '0) && escaped)
                            begin
                                state_reg <= S_COUNT;
                            end
                            else if (it_reg == max_iter_reg)
                            begin
                                state_reg <= S_COUNT;
                            end
                            else
                            begin
                                it_reg    <= it_reg + mbae_pkg::ITER_W'(1);
                                phase_reg <= PH_RR;
                            end
                        end
                    endcase
                end
                S_COUNT:
                begin
                    if (outside_reg && (count_reg != mbae_pkg::COUNT_MAX))
                    begin
                        count_reg <= count_reg + mbae_pkg::COUNT_W'(1);
                    end
                    state_reg <= last_reg ? S_AREA_LOAD : S_FINISH;
                end
                S_AREA_LOAD:
                begin
                    dcnt_reg  <= DCNT_W'(DW);
                    state_reg <= S_DIV_A;
                end
                S_FINISH:
                begin
                    if (out_load)
                    begin
                        if (last_reg)
                        begin
                            count_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    dvd_reg  <= DW'({row5, {(FRAC_BITS - 1){1'b0}}});
                    rem_reg  <= '0;
                    dvsr_reg <= DVSR_W'(n_eff);
                    col_reg  <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
                    last_reg <= s_axis_tlast;
                end
            end
            S_DIV_R, S_DIV_I, S_DIV_A:
            begin
                dvd_reg <= dvd_next;
                rem_reg <= rem_next;
            end
            S_LOAD_I:
            begin
                cr_reg  <= coord_fix;
                dvd_reg <= DW'({col9, {(FRAC_BITS - 3){1'b0}}});
                rem_reg <= '0;
            end
            S_LOAD_Z:
            begin
                ci_reg      <= coord_fix;
                zi_reg      <= coord_fix;
                zr_reg      <= cr_reg;
                outside_reg <= 1'b0;
            end
            S_ITER:
            begin
                unique case (phase_reg)
                    PH_RR:
                    begin
                        sq_r_reg <= mul_fl;
                        if (it_reg != '0)
                        begin
                            zi_reg <= zi_upd;
                        end
                    end
                    PH_II:
                    begin
                        sq_i_reg <= mul_fl;
                    end
                    default:
                    begin
                        outside_reg <= (it_reg != '0) && escaped;
                        xp_reg      <= mul_fl;
                        zr_reg      <= zr_upd;
                    end
                endcase
            end
            S_COUNT:
            begin
                total_reg <= DVSR_W'(n_eff) * DVSR_W'(n_eff);
            end
            S_AREA_LOAD:
            begin
                dvd_reg  <= {prod45, {(FRAC_BITS - 3){1'b0}}};
                rem_reg  <= '0;
                dvsr_reg <= total_reg;
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    flag_out_reg  <= outside_reg;
                    total_out_reg <= count_reg;
                    area_out_reg  <= last_reg ? dvd_reg[AREA_W-1:0] : '0;
                    last_out_reg  <= last_reg;
                end
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({area_out_reg, total_out_reg, flag_out_reg});
    assign m_axis_tlast  = last_out_reg;

endmodule

@@ rtl/core/mbae_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the Mandelbrot area estimator, bound to the top level.
// Depends on mbae_pkg for widths and on the top level's port list.
module mbae_checker #(
    parameter int COORD_BITS = mbae_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = mbae_pkg::FRAC_BITS_DEF,
    localparam int IN_W      = ((2 * COORD_BITS + 7) / 8) * 8,
    localparam int AREA_W    = FRAC_BITS + 3,
    localparam int OUT_W     = ((1 + mbae_pkg::COUNT_W + AREA_W + 7) / 8) * 8
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_wr_en,
    input logic [mbae_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [mbae_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [IN_W-1:0]                  s_axis_tdata,
    input logic                             s_axis_tlast,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [OUT_W-1:0]                 m_axis_tdata,
    input logic                             m_axis_tlast
);

    localparam int AREA_LO = 1 + mbae_pkg::COUNT_W;

    // A pending result is never withdrawn before the receiver takes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output transaction dropped while stalled");

    // Each point is worked on alone, so the core stops accepting after a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a point is in progress");

    // The area field carries a value only on the result that closes a sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[AREA_LO+AREA_W-1:AREA_LO] == '0)
        else $error("area reported outside a sweep end");

    // An outside point is included in the running count it reports.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[AREA_LO-1:1] != '0)
        else $error("outside point with zero running count");

endmodule

bind mandelbrot_area_estimator mbae_checker #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
) u_mbae_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
